/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define A2C_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define A2C_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* design/a2c_pkg.sv */
// Package: types, token table and helper functions of the charset encoder.
`timescale 1ns / 1ps

package a2c_pkg;

    localparam int TABLE_ENTRIES   = 36;
    localparam int MAX_TOKEN_CHARS = 3;

    localparam logic [8:0] BUFSIZE_RESET = 9'd32;
    localparam logic [7:0] CODE_TERM     = 8'hFF;
    localparam logic [7:0] CODE_UPPER    = 8'h0A;
    localparam logic [7:0] CODE_LOWER    = 8'h24;

    // One window character with its stand-alone mapping worked out up front.
    typedef struct packed {
        logic [7:0] ch;
        logic       map_ok;
        logic [7:0] map_code;
    } t_char;

    // Queue entry.
    typedef struct packed {
        t_char c;
        logic  eos;
    } t_item;

    // Front to queue.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

    // Queue head to back.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
        logic [1:0] len;
    } t_match;

    // Token text, first character in the low byte.
    localparam logic [23:0] TOK_TEXT [TABLE_ENTRIES] = '{
        24'h5D5E5B, 24'h5D765B, 24'h5D3C5B, 24'h5D3E5B,
        24'h5D415B, 24'h5D425B, 24'h5D435B, 24'h5D5A5B,
        24'h5D525B, 24'h656874, 24'h756F79, 24'h3E2D3C,
        24'h2E2E2E, 24'h5D2B5B, 24'h5D2A5B, 24'h5D785B,
        24'h5D2D5B, 24'h5D2E5B, 24'h002020, 24'h002829,
        24'h000027, 24'h00002E, 24'h00002C, 24'h000020,
        24'h00002D, 24'h000028, 24'h000029, 24'h000026,
        24'h00003A, 24'h000021, 24'h000025, 24'h00003F,
        24'h00007B, 24'h00007D, 24'h00007E, 24'h00000A
    };

    localparam logic [7:0] TOK_CODE [TABLE_ENTRIES] = '{
        8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
        8'h58, 8'hD1, 8'hD2, 8'hE4, 8'hF8, 8'hF9, 8'hFA, 8'hFB,
        8'hFC, 8'hFD, 8'hD0, 8'hE2, 8'h3E, 8'h3F, 8'h6F, 8'h9E,
        8'h9F, 8'hE1, 8'hE3, 8'hE5, 8'hE6, 8'hF2, 8'hF3, 8'hF4,
        8'hF5, 8'hF6, 8'hF7, 8'hFE
    };

    localparam logic [1:0] TOK_LEN [TABLE_ENTRIES] = '{
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
        2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1
    };

    // Stand-alone mapping of digits and letters.
    function automatic t_char classify(input logic [7:0] ch);
        t_char c;
        c.ch       = ch;
        c.map_ok   = 1'b0;
        c.map_code = 8'h00;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            c.map_ok   = 1'b1;
            c.map_code = ch - 8'h30;
        end else if (ch >= 8'h41 && ch <= 8'h5A) begin
            c.map_ok   = 1'b1;
            c.map_code = CODE_UPPER + (ch - 8'h41);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            c.map_ok   = 1'b1;
            c.map_code = CODE_LOWER + (ch - 8'h61);
        end
        return c;
    endfunction

    // Parallel compare against the table; the lowest matching entry wins.
    function automatic t_match token_lookup(input logic [23:0] chars,
                                            input logic [1:0]  max_len);
        t_match m;
        logic   ok;
        m = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            ok = (TOK_LEN[i] <= max_len);
            for (int k = 0; k < MAX_TOKEN_CHARS; k++) begin
                if (k < int'(TOK_LEN[i]))
                    ok = ok && (chars[8*k +: 8] == TOK_TEXT[i][8*k +: 8]);
            end
            if (ok) begin
                m.hit  = 1'b1;
                m.code = TOK_CODE[i];
                m.len  = TOK_LEN[i];
            end
        end
        return m;
    endfunction

    // Slots a string gets for a buffer size, terminator excluded.
    function automatic logic [7:0] slots_for(input logic [8:0] bs);
        logic [7:0] s;
        if (bs <= 9'd1)
            s = 8'd0;
        else if (bs >= 9'd256)
            s = 8'd255;
        else
            s = bs[7:0] - 8'd1;
        return s;
    endfunction

endpackage

/* design/ascii_to_charset_code_encoder.sv */
// Top level of the ASCII to character-code encoder.
`timescale 1ns / 1ps

// Takes one ASCII character per request and emits 8-bit character codes,
// resolving tokens greedily over a three-character lookahead window against
// a fixed 36-entry table, then mapping digits and letters, and closing each
// string with the 0xFF terminator on tlast. A character request is taken
// every cycle while the queue has room and is resolved by the table compare
// in the back end; an end-of-string request stays at the queue head while
// up to two remaining tokens, then the terminator, go out. A two-entry queue sits
// between the front end and the back end, and a registered output stage lets
// new requests enter while a code waits on the master side. Writing the
// buffer size (terminator included) abandons any string in progress and is
// expected only while the block is idle.
module ascii_to_charset_code_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] character
    input  logic       i_s_axis_tlast,   // end_of_string
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] code
    output logic       o_m_axis_tlast,   // last_of_string
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [8:0] i_cfg_data        // buffer_size
);

    a2c_pkg::t_push  w_push;
    a2c_pkg::t_qhead w_head;
    logic            w_q_ready;
    logic            w_pop;

    a2c_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_q_ready       (w_q_ready),
        .o_push          (w_push)
    );

    a2c_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    a2c_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    assign o_cfg_ready = 1'b1;

endmodule

/* design/a2c_front.sv */
// Front end: takes input requests and classifies each character.
`timescale 1ns / 1ps

module a2c_front (
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,   // character
    input  logic               i_s_axis_tlast,   // end_of_string
    input  logic               i_q_ready,
    output a2c_pkg::t_push     o_push
);

    a2c_pkg::t_item w_item;

    always_comb begin
        w_item.c   = a2c_pkg::classify(i_s_axis_tdata);
        // a NUL character ends the string just like tlast
        w_item.eos = i_s_axis_tlast || (i_s_axis_tdata == 8'h00);
    end

    assign o_s_axis_tready = i_q_ready;
    assign o_push.valid    = i_s_axis_tvalid && i_q_ready;
    assign o_push.item     = w_item;

endmodule

/* design/a2c_queue.sv */
// Two-entry queue between front end and resolver.
`timescale 1ns / 1ps

module a2c_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  a2c_pkg::t_push     i_push,
    output logic               o_ready,
    output a2c_pkg::t_qhead    o_head,
    input  logic               i_pop
);

    a2c_pkg::t_item r_mem [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        if (i_push.valid && !i_pop)
            n_count = r_count + 2'd1;
        else if (!i_push.valid && i_pop)
            n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    assign o_ready      = (r_count != 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

/* design/a2c_back.sv */
// Back end: lookahead window, token resolver, slot count and output register.
`timescale 1ns / 1ps

module a2c_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  a2c_pkg::t_qhead    i_head,
    output logic               o_pop,
    input  logic               i_cfg_valid,
    input  logic [8:0]         i_cfg_data,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [7:0]         o_m_axis_tdata,   // code
    output logic               o_m_axis_tlast    // last_of_string
);

    a2c_pkg::t_char r_win [a2c_pkg::MAX_TOKEN_CHARS];
    a2c_pkg::t_char n_win [a2c_pkg::MAX_TOKEN_CHARS];
    a2c_pkg::t_char w_res [a2c_pkg::MAX_TOKEN_CHARS];
    logic [1:0]     r_fill, n_fill;
    logic [7:0]     r_slots, n_slots;
    logic           r_stopped, n_stopped;
    logic [8:0]     r_bufsize;
    logic           r_out_valid;
    logic [7:0]     r_out_code;
    logic           r_out_last;

    a2c_pkg::t_match w_match;
    logic [1:0]      w_res_fill;
    logic [1:0]      w_max_len;
    logic [1:0]      w_used;
    logic [7:0]      w_slots_dec;
    logic            w_eos;
    logic            w_active;
    logic            w_resolve;
    logic            w_got;
    logic [7:0]      w_code;
    logic            w_emit;
    logic [7:0]      w_emit_code;
    logic            w_emit_last;
    logic            w_out_free;
    logic            w_step;

    always_comb begin
        w_eos    = i_head.item.eos;
        w_active = !r_stopped && (r_slots != 8'd0);

        // window as seen by the resolver
        w_res      = r_win;
        w_res_fill = r_fill;
        if (!w_eos && r_fill != 2'd3) begin
            w_res[r_fill] = i_head.item.c;
            w_res_fill    = r_fill + 2'd1;
        end

        if (w_eos)
            w_resolve = !r_stopped && (r_fill != 2'd0) && (r_slots != 8'd0);
        else
            w_resolve = w_active && (w_res_fill == 2'd3);

        if (r_slots < {6'd0, w_res_fill})
            w_max_len = r_slots[1:0];
        else
            w_max_len = w_res_fill;

        w_match = a2c_pkg::token_lookup({w_res[2].ch, w_res[1].ch, w_res[0].ch},
                                        w_max_len);
        w_used  = w_match.hit ? w_match.len : 2'd1;
        w_got   = w_match.hit || w_res[0].map_ok;
        w_code  = w_match.hit ? w_match.code : w_res[0].map_code;

        w_emit      = w_resolve ? w_got : w_eos;
        w_emit_code = w_resolve ? w_code : a2c_pkg::CODE_TERM;
        w_emit_last = !w_resolve;

        w_out_free = !r_out_valid || i_m_axis_tready;
        w_step     = i_head.valid && (!w_emit || w_out_free);
        // an end request stays at the head until its terminator goes out
        o_pop      = w_step && !(w_eos && w_resolve);

        w_slots_dec = r_slots - 8'd1;

        n_win     = r_win;
        n_fill    = r_fill;
        n_slots   = r_slots;
        n_stopped = r_stopped;
        if (w_step) begin
            if (w_resolve) begin
                unique case (w_used)
                    2'd1: begin
                        n_win[0] = w_res[1];
                        n_win[1] = w_res[2];
                    end
                    2'd2: begin
                        n_win[0] = w_res[2];
                    end
                    default: begin
                        n_win = w_res;
                    end
                endcase
                n_fill  = w_res_fill - w_used;
                n_slots = w_slots_dec;
                if (w_slots_dec == 8'd0) begin
                    n_stopped = 1'b1;
                    n_fill    = 2'd0;
                end
            end else if (w_eos) begin
                n_fill    = 2'd0;
                n_stopped = 1'b0;
                n_slots   = a2c_pkg::slots_for(r_bufsize);
            end else if (w_active) begin
                n_win  = w_res;
                n_fill = w_res_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bufsize <= a2c_pkg::BUFSIZE_RESET;
            r_fill    <= 2'd0;
            r_slots   <= a2c_pkg::slots_for(a2c_pkg::BUFSIZE_RESET);
            r_stopped <= 1'b0;
        end else if (i_cfg_valid) begin
            // a new size abandons the string in progress
            r_bufsize <= i_cfg_data;
            r_fill    <= 2'd0;
            r_slots   <= a2c_pkg::slots_for(i_cfg_data);
            r_stopped <= 1'b0;
        end else begin
            r_fill    <= n_fill;
            r_slots   <= n_slots;
            r_stopped <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out_code <= w_emit_code;
            r_out_last <= w_emit_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_code;
    assign o_m_axis_tlast  = r_out_last;

endmodule

/* design/a2c_checker.sv */
// Port-level checker for the encoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module a2c_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);

    // only the terminator carries 0xFF, and it always carries tlast
    `A2C_ASSERT(a_term_code, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata == 8'hFF)))

    `A2C_ASSERT_ALWAYS(a_no_out_after_rst, i_clk, $past(!i_rst_n) |-> !o_m_axis_tvalid)

    `A2C_ASSERT(a_valid_holds, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)

    `A2C_ASSERT(a_data_holds, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> ($stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))

endmodule

bind ascii_to_charset_code_encoder a2c_checker u_a2c_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

/* tb/sv/ascii_to_charset_code_encoder_tb.sv */
// Testbench for the ASCII to character-code encoder: directed and random strings.
`timescale 1ns / 1ps

module ascii_to_charset_code_encoder_tb;

    localparam int NUM_TOKENS   = 36;
    localparam int WINDOW_CHARS = 3;
    localparam int SETTLE_WAIT  = 8;
    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_SETS  = 2;
    localparam int ITEMS_PER_SET = 28;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_code_rec;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;
    logic       i_s_axis_tlast = 1'b0;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [8:0] i_cfg_data = 9'd0;

    ascii_to_charset_code_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Token strings in priority order; first hit wins.
    string tok_txt [NUM_TOKENS] = '{
        "[^]", "[v]", "[<]", "[>]", "[A]", "[B]", "[C]", "[Z]",
        "[R]", "the", "you", "<->", "...", "[+]", "[*]", "[x]",
        "[-]", "[.]", "  ", ")(", "'", ".", ",", " ",
        "-", "(", ")", "&", ":", "!", "%", "?",
        "{", "}", "~", "\n"
    };
    logic [7:0] tok_code [NUM_TOKENS] = '{
        8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
        8'h58, 8'hD1, 8'hD2, 8'hE4, 8'hF8, 8'hF9, 8'hFA, 8'hFB,
        8'hFC, 8'hFD, 8'hD0, 8'hE2, 8'h3E, 8'h3F, 8'h6F, 8'h9E,
        8'h9F, 8'hE1, 8'hE3, 8'hE5, 8'hE6, 8'hF2, 8'hF3, 8'hF4,
        8'hF5, 8'hF6, 8'hF7, 8'hFE
    };

    // Encoder state mirror
    logic [8:0] bufsize_reg;
    logic [7:0] win [WINDOW_CHARS];
    int         win_fill;
    int         slots_left;
    bit         string_stopped;

    t_code_rec  pending_codes [$];
    int         error_count = 0;
    int         items_used = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         quiet_cycles = 0;

    function automatic void start_string();
        int bs;
        bs = bufsize_reg;
        if (bs == 0) bs = 1;
        if (bs > 256) bs = 256;
        foreach (win[k]) win[k] = 8'h00;
        win_fill = 0;
        slots_left = bs - 1;
        string_stopped = 1'b0;
    endfunction

    function automatic void drop_front(input int n);
        if (n >= win_fill) begin
            win_fill = 0;
            foreach (win[k]) win[k] = 8'h00;
        end else begin
            for (int k = 0; k < win_fill - n; k++) win[k] = win[k + n];
            win_fill -= n;
            for (int k = win_fill; k < WINDOW_CHARS; k++) win[k] = 8'h00;
        end
    endfunction

    // Resolves one token at the window front; returns 1 if it yields a code.
    function automatic bit resolve_token(output logic [7:0] code);
        int         len;
        bit         hit;
        bit         got;
        logic [7:0] c;
        hit = 1'b0;
        got = 1'b0;
        code = 8'h00;
        for (int i = 0; i < NUM_TOKENS && !hit; i++) begin
            len = tok_txt[i].len();
            if (len <= win_fill && slots_left >= len) begin
                hit = 1'b1;
                for (int k = 0; k < len; k++)
                    if (win[k] != tok_txt[i][k]) hit = 1'b0;
                if (hit) begin
                    code = tok_code[i];
                    got = 1'b1;
                    drop_front(len);
                end
            end
        end
        if (!hit) begin
            c = win[0];
            if (c >= "0" && c <= "9") begin
                code = c - "0";
                got = 1'b1;
            end else if (c >= "A" && c <= "Z") begin
                code = a2c_pkg::CODE_UPPER + (c - "A");
                got = 1'b1;
            end else if (c >= "a" && c <= "z") begin
                code = a2c_pkg::CODE_LOWER + (c - "a");
                got = 1'b1;
            end
            drop_front(1);
        end
        if (slots_left > 0) slots_left--;
        if (slots_left == 0) begin
            string_stopped = 1'b1;
            drop_front(WINDOW_CHARS);
        end
        return got;
    endfunction

    // Queues the codes one accepted request produces; returns 0 if it is ignored.
    function automatic bit predict_request(input logic [7:0] ch, input logic eos);
        logic [7:0] code;
        int         n;
        n = 0;
        if (!(eos || ch == 8'h00)) begin
            if (string_stopped || slots_left == 0) return 1'b0;
            if (win_fill < WINDOW_CHARS) begin
                win[win_fill] = ch;
                win_fill++;
            end
            if (win_fill >= WINDOW_CHARS && resolve_token(code))
                pending_codes.push_back('{code: code, last: 1'b0});
            return 1'b1;
        end
        // drain what is left in the window, then close the string
        while (!string_stopped && win_fill > 0 && slots_left > 0 && n < 3) begin
            if (resolve_token(code)) begin
                pending_codes.push_back('{code: code, last: 1'b0});
                n++;
            end
        end
        pending_codes.push_back('{code: a2c_pkg::CODE_TERM, last: 1'b1});
        start_string();
        return 1'b1;
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic eos);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        i_s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!o_s_axis_tready);
        void'(predict_request(ch, eos));
        items_used++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k], 1'b0);
    endtask

    // Stops the request stream and lets every expected code drain out.
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_buffer_size(input logic [8:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        bufsize_reg = value;
        start_string();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Table hits of three and two characters, letter and digit extremes, a dropped byte.
    task automatic test_token_mix();
        send_text("[A]the  )(Zz09");
        send_char(8'hFF, 1'b0);
        send_char(8'h5A, 1'b1);
    endtask

    // Partial 3-char token left at the end: no match on a short window.
    task automatic test_short_window();
        send_text("[A");
        send_char(8'h00, 1'b0);
    endtask

    // Two slots: "the" cannot fit, slots run out, trailing chars ignored.
    task automatic test_slot_exhaustion();
        write_buffer_size(9'd3);
        send_text("thex");
        send_char(8'h61, 1'b1);
    endtask

    // Zero acts as one (terminator only); out-of-range size clamps to 256.
    task automatic test_buffer_limits();
        write_buffer_size(9'd0);
        send_char(8'h00, 1'b1);
        write_buffer_size(9'd511);
        send_text("q");
        send_char(8'h00, 1'b1);
    endtask

    // A size write drops the half-built string.
    task automatic test_config_abandon();
        send_text("ab");
        write_buffer_size(9'd256);
        send_text("c");
        send_char(8'h00, 1'b1);
    endtask

    function automatic logic [8:0] pick_buffer_size();
        case ($urandom_range(9))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'd511;
            4, 5, 6: return 9'($urandom_range(6, 2));
            default: return 9'($urandom_range(40, 7));
        endcase
    endfunction

    task automatic send_random_string();
        string      tok;
        int         n_pieces;
        logic [7:0] txt [$];
        if ($urandom_range(9) < 8) begin
            n_pieces = $urandom_range(6, 1);
            repeat (n_pieces) begin
                tok = tok_txt[$urandom_range(NUM_TOKENS - 1)];
                case ($urandom_range(6))
                    0: for (int k = 0; k < tok.len(); k++) txt.push_back(tok[k]);
                    1: txt.push_back(8'("a" + $urandom_range(25)));
                    2: txt.push_back(8'("A" + $urandom_range(25)));
                    3: txt.push_back(8'("0" + $urandom_range(9)));
                    4: txt.push_back(" ");
                    5: txt.push_back(8'($urandom_range(255, 1)));
                    // token prefix, to leave a near miss in the window
                    default: for (int k = 0; k < tok.len() - 1; k++) txt.push_back(tok[k]);
                endcase
            end
            foreach (txt[k]) send_char(txt[k], 1'b0);
            if ($urandom_range(1))
                send_char(8'($urandom_range(255)), 1'b1);
            else
                send_char(8'h00, 1'b0);
        end else begin
            // noise: may end early, or leave the string open
            repeat ($urandom_range(8, 1))
                send_char(8'($urandom_range(255)), $urandom_range(15) == 0);
        end
    endtask

    task automatic test_random_strings();
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int set = 0; set < RANDOM_SETS; set++) begin
                write_buffer_size(pick_buffer_size());
                target = items_used + ITEMS_PER_SET;
                while (items_used < target) send_random_string();
            end
        end
    endtask

    always @(negedge i_clk)
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Result checker
    always @(posedge i_clk) begin
        t_code_rec want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_codes.size() == 0) begin
                $display("%0t: unexpected code: expected none, actual %02h last %0b",
                         $time, o_m_axis_tdata, o_m_axis_tlast);
                error_count++;
            end else begin
                want = pending_codes.pop_front();
                if (o_m_axis_tdata !== want.code) begin
                    $display("%0t: code mismatch: expected %02h, actual %02h",
                             $time, want.code, o_m_axis_tdata);
                    error_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, o_m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no handshake at all.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("ascii_to_charset_code_encoder verification failed");
                $finish;
            end
        end
    end

    initial begin
        bufsize_reg = a2c_pkg::BUFSIZE_RESET;
        start_string();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_token_mix();
        test_short_window();
        test_slot_exhaustion();
        test_buffer_limits();
        test_config_abandon();
        test_random_strings();

        wait_idle();
        if (error_count == 0)
            $display("ascii_to_charset_code_encoder verification clean");
        else
            $display("ascii_to_charset_code_encoder verification failed");
        $finish;
    end

endmodule
